/* hdl/pts_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared constants and transaction types for the scheduler core.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MaxTasksDefault = 16;
   localparam int KeyBitsDefault  = 16;

   localparam logic [2:0] REQ_REGISTER = 3'd0;
   localparam logic [2:0] REQ_REMOVE   = 3'd1;
   localparam logic [2:0] REQ_SET_EN   = 3'd2;
   localparam logic [2:0] REQ_SET_PER  = 3'd3;
   localparam logic [2:0] REQ_TICK     = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] task_key;
      logic [31:0] interval_ms;
      logic        enable;
      logic [31:0] now_ms;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        fired;
      logic [15:0] fired_key;
      logic [31:0] lateness_ms;
      logic        last;
   } rsp_type_type;

endpackage

/* hdl/periodic_task_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Periodic task scheduler core
// Ordered task table with register, remove, update and tick transactions.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A sequencer walks the task table one
// slot at a time (read, then compare or evaluate) with a single key
// comparator and a chained pair of 32-bit subtracters for elapsed time and
// lateness. A remove then shifts each later slot down one place. A stalled
// result holds up a tick walk and the closing result. Results sit in an
// output register; req_stall is high while a transaction is under way. Tick
// results announce each fired task with its lateness and finish with a
// closing result marked last; with the priority bit set, a tick stops after
// its first fired task. Table slots need no clearing after reset.
module periodic_task_scheduler_core
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = MaxTasksDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type_type rsp_data,
   input  logic         csr_write,
   input  logic         csr_wdata
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_TREAD  = 3'd3;
   localparam logic [2:0] S_TEVAL  = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_WAIT   = 3'd6;

   // task table memories
   logic [15:0] key_mem [MAX_TASKS];
   logic [31:0] per_mem [MAX_TASKS];
   logic        en_mem  [MAX_TASKS];
   logic [31:0] lf_mem  [MAX_TASKS];

   logic [2:0]   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          prio_ff;
   req_type_type  req_ff;
   rsp_type_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          done_ff, done_in;  // set while the evaluate state does a shift step
   logic [1:0]    st_ff, st_in;      // status for the closing result

   // registered read of slot idx
   logic [15:0] rd_key_ff;
   logic [31:0] rd_per_ff, rd_lf_ff;
   logic        rd_en_ff;

   // table write port
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [15:0]   wr_key;
   logic [31:0]   wr_per, wr_lf;
   logic          wr_ena;
   logic [IW-1:0] rd_idx;

   logic [31:0] elapsed, late;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_idx  = idx_ff[IW-1:0];
   assign elapsed = req_ff.now_ms - rd_lf_ff;
   assign late    = elapsed - rd_per_ff;

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_idx];
      rd_per_ff <= per_mem[rd_idx];
      rd_en_ff  <= en_mem[rd_idx];
      rd_lf_ff  <= lf_mem[rd_idx];
      if (wr_en) begin
         key_mem[wr_idx] <= wr_key;
         per_mem[wr_idx] <= wr_per;
         en_mem[wr_idx]  <= wr_ena;
         lf_mem[wr_idx]  <= wr_lf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         prio_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         if (csr_write) begin
            prio_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      st_ff  <= st_in;
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   function automatic rsp_type_type close_rsp(input logic [1:0] st);
      rsp_type_type r;
      r = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      done_in      = done_ff;
      st_in        = st_ff;
      wr_en        = 1'b0;
      wr_idx       = rd_idx;
      wr_key       = rd_key_ff;
      wr_per       = rd_per_ff;
      wr_ena       = rd_en_ff;
      wr_lf        = rd_lf_ff;

      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               state_in = (req_data.req_type == REQ_TICK) ? S_TREAD : S_SEARCH;
            end
         end
         // idx_ff addresses the slot whose data arrive next cycle; the
         // comparison runs on those data of slot idx_ff in the wait state
         S_SEARCH: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            // rd_* hold slot idx_ff
            if (idx_ff >= count_ff) begin
               // no match
               if (req_ff.req_type == REQ_REGISTER) begin
                  if (count_ff < CW'(MAX_TASKS)) begin
                     wr_en    = 1'b1;
                     wr_idx   = count_ff[IW-1:0];
                     wr_key   = req_ff.task_key;
                     wr_per   = req_ff.interval_ms;
                     wr_ena   = req_ff.enable;
                     wr_lf    = '0;
                     count_in = count_ff + 1'b1;
                     st_in    = STATUS_OK;
                  end else begin
                     st_in = STATUS_FULL;
                  end
               end else if (req_ff.req_type == REQ_REMOVE ||
                            req_ff.req_type == REQ_SET_EN ||
                            req_ff.req_type == REQ_SET_PER) begin
                  st_in = STATUS_NOT_FOUND;
               end else begin
                  st_in = STATUS_OK;
               end
               state_in = S_EMIT;
            end else if (rd_key_ff == req_ff.task_key &&
                         req_ff.req_type <= REQ_SET_PER) begin
               st_in = STATUS_OK;
               case (req_ff.req_type)
                  REQ_REGISTER: begin
                     wr_en  = 1'b1;
                     wr_per = req_ff.interval_ms;
                     wr_ena = req_ff.enable;
                     state_in = S_EMIT;
                  end
                  REQ_SET_EN: begin
                     wr_en  = 1'b1;
                     wr_ena = req_ff.enable;
                     state_in = S_EMIT;
                  end
                  REQ_SET_PER: begin
                     wr_en  = 1'b1;
                     wr_per = req_ff.interval_ms;
                     state_in = S_EMIT;
                  end
                  default: begin
                     // remove: pull later slots down one at a time
                     count_in = count_ff - 1'b1;
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_SHIFT;
                  end
               endcase
            end else if (req_ff.req_type > REQ_SET_PER) begin
               st_in    = STATUS_OK;
               state_in = S_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SHIFT: begin
            // rd_* not yet valid for idx_ff; go through a read cycle
            if (idx_ff > count_ff) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_TEVAL;
               done_in  = 1'b1;  // marks shift mode in the evaluate state
            end
         end
         S_TREAD: begin
            if (idx_ff >= count_ff) begin
               st_in    = STATUS_OK;
               state_in = S_EMIT;
            end else begin
               state_in = S_TEVAL;
            end
         end
         S_TEVAL: begin
            if (done_ff) begin
               // shift slot idx down into idx-1
               wr_en    = 1'b1;
               wr_idx   = IW'(idx_ff - 1'b1);
               idx_in   = idx_ff + 1'b1;
               done_in  = 1'b0;
               state_in = S_SHIFT;
            end else if (rd_key_ff != '0 && rd_en_ff && elapsed >= rd_per_ff) begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  wr_en = 1'b1;
                  if (elapsed >= {rd_per_ff[30:0], 1'b0} || rd_lf_ff == '0) begin
                     wr_lf = req_ff.now_ms;
                  end else begin
                     wr_lf = rd_lf_ff + rd_per_ff;
                  end
                  rsp_in             = '0;
                  rsp_in.fired       = 1'b1;
                  rsp_in.fired_key   = rd_key_ff;
                  rsp_in.lateness_ms = late;
                  rsp_valid_in       = 1'b1;
                  idx_in   = prio_ff ? count_ff : idx_ff + 1'b1;
                  state_in = S_TREAD;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TREAD;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = close_rsp(st_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
